[rtl/core/u8u16_pkg.sv]
package u8u16_pkg;

    typedef enum logic [1:0] {
        JOB_UNIT,
        JOB_PAIR,
        JOB_REPL
    } job_kind_t;

    // one queued transaction for the back end
    typedef struct packed {
        job_kind_t   kind;
        logic [20:0] cp;
        logic [1:0]  cnt_m1;
    } job_t;

    localparam logic [15:0] REPL_UNIT   = 16'hFFFD;
    localparam logic [15:0] HI_SURR     = 16'hD800;
    localparam logic [15:0] LO_SURR     = 16'hDC00;
    localparam logic [20:0] SUPP_BASE   = 21'h010000;
    localparam logic [20:0] CP_MAX      = 21'h10FFFF;
    localparam logic [20:0] SURR_FIRST  = 21'h00D800;
    localparam logic [20:0] SURR_LAST   = 21'h00DFFF;
    localparam logic [20:0] MIN_LEN1    = 21'h000080;
    localparam logic [20:0] MIN_LEN2    = 21'h000800;
    localparam logic [20:0] MIN_LEN3    = 21'h010000;
    localparam logic [7:0]  ASCII_LAST  = 8'h7F;
    localparam logic [7:0]  LEAD2_FIRST = 8'hC2;
    localparam logic [7:0]  LEAD2_LAST  = 8'hDF;
    localparam logic [7:0]  LEAD3_FIRST = 8'hE0;
    localparam logic [7:0]  LEAD3_LAST  = 8'hEF;
    localparam logic [7:0]  LEAD4_FIRST = 8'hF0;
    localparam logic [7:0]  LEAD4_LAST  = 8'hF4;

endpackage

[rtl/core/utf8_to_utf16_decoder.sv]
// UTF-8 to UTF-16 decoder with U+FFFD replacement.
// A byte's first result passes through the job queue and then the output register before it is presented.
// Throughput: one byte per cycle while the job queue has room; one code unit per cycle out while m_tready is high.
// A byte producing N units (up to 4) holds its queue slot until its last unit is loaded into the output stage.
// Reset: synchronous, active low; clears sequence state, the queue and the output stage.
module utf8_to_utf16_decoder
    import u8u16_pkg::*;
#(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] data_byte
    input  logic        s_tlast,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // [15:0] code_unit
    output logic [0:0]  m_tuser,   // [0] is_replacement
    output logic        m_tlast
);

    logic byte_accept;
    logic job_valid;
    job_t job;
    logic full;
    logic head_valid;
    job_t head_data;
    logic pop;

    assign s_tready    = !full;
    assign byte_accept = s_tvalid && s_tready;

    u8u16_front u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .byte_accept (byte_accept),
        .data_byte   (s_tdata),
        .stream_end  (s_tlast),
        .job_valid   (job_valid),
        .job         (job)
    );

    u8u16_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (byte_accept && job_valid),
        .push_data  (job),
        .full       (full),
        .pop        (pop),
        .head_valid (head_valid),
        .head_data  (head_data)
    );

    u8u16_back u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .head_valid (head_valid),
        .head_data  (head_data),
        .pop        (pop),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser),
        .m_tlast    (m_tlast)
    );

endmodule

[rtl/core/u8u16_front.sv]
module u8u16_front
    import u8u16_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       byte_accept,
    input  logic [7:0] data_byte,
    input  logic       stream_end,
    output logic       job_valid,
    output job_t       job
);

    logic [1:0]  pending_reg, pending_next;
    logic [1:0]  seq_len_reg, seq_len_next;
    logic [20:0] acc_reg, acc_next;
    logic        broken_reg, broken_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pending_reg <= '0;
            seq_len_reg <= '0;
            acc_reg     <= '0;
            broken_reg  <= 1'b0;
        end else if (byte_accept) begin
            pending_reg <= pending_next;
            seq_len_reg <= seq_len_next;
            acc_reg     <= acc_next;
            broken_reg  <= broken_next;
        end
    end

    always_comb begin
        logic [1:0]  lead_len;
        logic [20:0] lead_acc;
        logic [20:0] min_cp;
        lead_len     = '0;
        lead_acc     = '0;
        min_cp       = MIN_LEN3;
        pending_next = pending_reg;
        seq_len_next = seq_len_reg;
        acc_next     = acc_reg;
        broken_next  = broken_reg;
        job_valid    = 1'b0;
        job.kind     = JOB_UNIT;
        job.cp       = '0;
        job.cnt_m1   = '0;

        if (pending_reg == 2'd0) begin
            if (data_byte <= ASCII_LAST) begin
                job_valid = 1'b1;
                job.cp    = {13'b0, data_byte};
            end else if (data_byte >= LEAD2_FIRST && data_byte <= LEAD2_LAST) begin
                lead_len = 2'd1;
                lead_acc = {16'b0, data_byte[4:0]};
            end else if (data_byte >= LEAD3_FIRST && data_byte <= LEAD3_LAST) begin
                lead_len = 2'd2;
                lead_acc = {17'b0, data_byte[3:0]};
            end else if (data_byte >= LEAD4_FIRST && data_byte <= LEAD4_LAST) begin
                lead_len = 2'd3;
                lead_acc = {18'b0, data_byte[2:0]};
            end else begin
                job_valid = 1'b1;
                job.kind  = JOB_REPL;
            end
            if (lead_len != 2'd0) begin
                pending_next = lead_len;
                seq_len_next = lead_len;
                acc_next     = lead_acc;
                broken_next  = 1'b0;
                if (stream_end) begin
                    job_valid = 1'b1;
                    job.kind  = JOB_REPL;
                end
            end
        end else begin
            if (!broken_reg) begin
                if (data_byte[7:6] == 2'b10) begin
                    acc_next = {acc_reg[14:0], data_byte[5:0]};
                end else begin
                    broken_next = 1'b1;
                end
            end
            pending_next = pending_reg - 2'd1;
            if (pending_next == 2'd0) begin
                job_valid = 1'b1;
                if (seq_len_reg == 2'd1) begin
                    min_cp = MIN_LEN1;
                end else if (seq_len_reg == 2'd2) begin
                    min_cp = MIN_LEN2;
                end
                if (broken_next) begin
                    job.kind = JOB_REPL;
                end else if (acc_next < min_cp || acc_next > CP_MAX ||
                             (acc_next >= SURR_FIRST && acc_next <= SURR_LAST)) begin
                    job.kind   = JOB_REPL;
                    job.cnt_m1 = seq_len_reg;
                end else if (acc_next < SUPP_BASE) begin
                    job.cp = acc_next;
                end else begin
                    job.kind = JOB_PAIR;
                    job.cp   = acc_next;
                end
                seq_len_next = '0;
                acc_next     = '0;
                broken_next  = 1'b0;
            end else if (stream_end) begin
                job_valid = 1'b1;
                job.kind  = JOB_REPL;
            end
        end

        if (stream_end) begin
            pending_next = '0;
            seq_len_next = '0;
            acc_next     = '0;
            broken_next  = 1'b0;
        end
    end

    a_end_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        byte_accept && stream_end |=> pending_reg == 2'd0 && !broken_reg && acc_reg == '0)
        else $error("state not cleared after end of stream");

    a_pend_len: assert property (@(posedge aclk) disable iff (!aresetn)
        pending_reg <= seq_len_reg)
        else $error("more bytes pending than claimed");

endmodule

[rtl/core/u8u16_fifo.sv]
module u8u16_fifo
    import u8u16_pkg::*;
#(
    parameter int DEPTH = 4
) (
    input  logic aclk,
    input  logic aresetn,
    input  logic push,
    input  job_t push_data,
    output logic full,
    input  logic pop,
    output logic head_valid,
    output job_t head_data
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    job_t             mem [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic             do_pop;

    assign full       = (count_reg == CNT_W'(DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_data  = mem[rd_ptr_reg];
    assign do_pop     = pop && head_valid;

    always_ff @(posedge aclk) begin
        if (push) begin
            mem[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_pop) begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (push && !do_pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (!push && do_pop) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        push |-> !full || do_pop)
        else $error("queue overflow");

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(DEPTH))
        else $error("queue count out of range");

endmodule

[rtl/core/u8u16_back.sv]
module u8u16_back
    import u8u16_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        head_valid,
    input  job_t        head_data,
    output logic        pop,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,
    output logic [0:0]  m_tuser,
    output logic        m_tlast
);

    logic        out_valid_reg;
    logic [15:0] unit_reg, unit_next;
    logic        repl_reg, repl_next;
    logic        last_reg, last_next;
    logic [1:0]  idx_reg;
    logic [1:0]  total_m1;
    logic [20:0] supp;
    logic        load;

    assign load = head_valid && (!out_valid_reg || m_tready);
    assign supp = head_data.cp - SUPP_BASE;

    always_comb begin
        total_m1  = 2'd0;
        unit_next = REPL_UNIT;
        repl_next = 1'b1;
        unique case (head_data.kind)
            JOB_UNIT: begin
                unit_next = head_data.cp[15:0];
                repl_next = 1'b0;
            end
            JOB_PAIR: begin
                total_m1  = 2'd1;
                repl_next = 1'b0;
                unit_next = (idx_reg == 2'd0) ? (HI_SURR + {6'b0, supp[19:10]})
                                              : (LO_SURR + {6'b0, supp[9:0]});
            end
            JOB_REPL: begin
                total_m1 = head_data.cnt_m1;
            end
            default: begin
                total_m1 = 2'd0;
            end
        endcase
        last_next = (idx_reg == total_m1);
    end

    assign pop = load && last_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
            idx_reg       <= '0;
        end else begin
            if (load) begin
                out_valid_reg <= 1'b1;
                idx_reg       <= last_next ? 2'd0 : idx_reg + 2'd1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            unit_reg <= unit_next;
            repl_reg <= repl_next;
            last_reg <= last_next;
        end
    end

    assign m_tvalid   = out_valid_reg;
    assign m_tdata    = unit_reg;
    assign m_tuser[0] = repl_reg;
    assign m_tlast    = last_reg;

    a_mid_job_head: assert property (@(posedge aclk) disable iff (!aresetn)
        idx_reg != 2'd0 |-> head_valid)
        else $error("job head lost mid-expansion");

    a_pop_marks_last: assert property (@(posedge aclk) disable iff (!aresetn)
        pop |=> m_tvalid && m_tlast)
        else $error("final unit of a transaction not flagged");

endmodule
